FILE: design/nsrl_pkg.sv
package nsrl_pkg;

  localparam int RATE_ENTRIES = 1024;
  localparam int EXC_ENTRIES  = 1024;
  localparam int RATE_IW      = $clog2(RATE_ENTRIES);
  localparam int RATE_CW      = $clog2(RATE_ENTRIES + 1);
  localparam int EXC_IW       = $clog2(EXC_ENTRIES);
  localparam int EXC_CW       = $clog2(EXC_ENTRIES + 1);

  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_DROP  = 2'd1;
  localparam logic [1:0] VERDICT_ABORT = 2'd2;

  localparam logic [1:0] CFG_PASS_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_WINDOW_NS    = 2'd1;
  localparam logic [1:0] CFG_WATCHED_PORT = 2'd2;
  localparam logic [1:0] CFG_BLOCKED_MODE = 2'd3;

  localparam logic       OP_CHECK  = 1'b0;
  localparam logic       OP_INSERT = 1'b1;

  localparam logic [15:0] MIN_CHECKED_LEN = 16'd43;
  localparam logic [15:0] ETH_IPV4        = 16'h0800;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;

  localparam logic [31:0] RST_PASS_LIMIT   = 32'd2;
  localparam logic [63:0] RST_WINDOW_NS    = 64'd1000000000;
  localparam logic [15:0] RST_WATCHED_PORT = 16'd123;
  localparam logic [2:0]  RST_BLOCKED_MODE = 3'd6;

  typedef struct packed {
    logic        opcode;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  first_payload_byte;
    logic [31:0] source_address;
    logic [63:0] time_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [63:0] blocked_total;
  } out_item_t;

  typedef struct packed {
    logic [63:0] start;
    logic [31:0] count;
    logic [63:0] total;
  } rate_rec_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic exc_insert;
    logic rate_new;
    logic rate_upd;
    logic set_pass;
    logic set_abort;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic checked;
    logic is_insert;
    logic exc_end;
    logic exc_hit;
    logic exc_full;
    logic rate_end;
    logic rate_hit;
    logic rate_full;
    logic out_blocked;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXC_RD,
    S_EXC_CMP,
    S_RATE_RD,
    S_RATE_CMP,
    S_UPD,
    S_FIN
  } state_t;

endpackage

FILE: design/nsrl_ctrl.sv
module nsrl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  nsrl_pkg::stat_t stat,
  output nsrl_pkg::cmd_t  cmd
);
  import nsrl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_EXC_RD;
        end
      end
      S_EXC_RD: begin
        if (!stat.is_insert && !stat.checked) begin
          cmd.set_pass = 1'b1;
          state_next   = S_FIN;
        end else if (stat.exc_end) begin
          // Address not in the exception table.
          if (stat.is_insert) begin
            if (stat.exc_full) begin
              cmd.set_abort = 1'b1;
            end else begin
              cmd.exc_insert = 1'b1;
              cmd.set_pass   = 1'b1;
            end
            state_next = S_FIN;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = S_RATE_RD;
          end
        end else begin
          state_next = S_EXC_CMP;
        end
      end
      S_EXC_CMP: begin
        if (stat.exc_hit) begin
          cmd.set_pass = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_EXC_RD;
        end
      end
      S_RATE_RD: begin
        if (stat.rate_end) begin
          if (stat.rate_full) begin
            cmd.set_abort = 1'b1;
          end else begin
            cmd.rate_new = 1'b1;
          end
          state_next = S_FIN;
        end else begin
          state_next = S_RATE_CMP;
        end
      end
      S_RATE_CMP: begin
        if (stat.rate_hit) begin
          state_next = S_UPD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_RATE_RD;
        end
      end
      S_UPD: begin
        cmd.rate_upd = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_blocked) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/nsrl_dp.sv
module nsrl_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  nsrl_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nsrl_pkg::out_item_t  out_item,
  input  nsrl_pkg::cmd_t       cmd,
  output nsrl_pkg::stat_t      stat
);
  import nsrl_pkg::*;

  localparam int IDX_W = (RATE_CW > EXC_CW) ? RATE_CW : EXC_CW;

  logic [31:0] pass_limit;
  logic [63:0] window_ns;
  logic [15:0] watched_port;
  logic [2:0]  blocked_mode;

  in_item_t           item;
  logic [IDX_W-1:0]   idx;
  logic [EXC_CW-1:0]  exc_fill;
  logic [RATE_CW-1:0] rate_fill;

  logic [31:0] exc_keys [EXC_ENTRIES];
  logic [31:0] rate_keys [RATE_ENTRIES];
  rate_rec_t   rate_recs [RATE_ENTRIES];
  logic [31:0] exc_rdata;
  logic [31:0] rate_key_rdata;
  rate_rec_t   rec_rdata;

  logic [EXC_IW-1:0]  exc_addr;
  logic [RATE_IW-1:0] rate_addr;

  out_item_t pend;
  logic      mode_blocked;
  rate_rec_t rec_next;
  rate_rec_t rec_new;
  logic [1:0] upd_verdict;
  logic [63:0] elapsed;
  logic [31:0] cnt_inc;
  logic [63:0] tot_inc;

  assign exc_addr  = idx[EXC_IW-1:0];
  assign rate_addr = idx[RATE_IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_limit   <= RST_PASS_LIMIT;
      window_ns    <= RST_WINDOW_NS;
      watched_port <= RST_WATCHED_PORT;
      blocked_mode <= RST_BLOCKED_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PASS_LIMIT:   pass_limit   <= cfg_data[31:0];
        CFG_WINDOW_NS:    window_ns    <= cfg_data;
        CFG_WATCHED_PORT: watched_port <= cfg_data[15:0];
        CFG_BLOCKED_MODE: blocked_mode <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Tables fill from slot zero and never release, so the fill count is the
  // lowest free slot and marks which entries are live.
  always_ff @(posedge clk) begin
    if (rst) begin
      exc_fill  <= '0;
      rate_fill <= '0;
    end else begin
      if (cmd.exc_insert) begin
        exc_fill <= exc_fill + 1'b1;
      end
      if (cmd.rate_new) begin
        rate_fill <= rate_fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exc_insert) begin
      exc_keys[exc_fill[EXC_IW-1:0]] <= item.source_address;
    end
    exc_rdata <= exc_keys[exc_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rate_new) begin
      rate_keys[rate_fill[RATE_IW-1:0]] <= item.source_address;
    end
    rate_key_rdata <= rate_keys[rate_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rate_new) begin
      rate_recs[rate_fill[RATE_IW-1:0]] <= rec_new;
    end else if (cmd.rate_upd) begin
      rate_recs[rate_addr] <= rec_next;
    end
    rec_rdata <= rate_recs[rate_addr];
  end

  assign mode_blocked = (item.first_payload_byte[2:0] == blocked_mode);

  always_comb begin
    rec_new.start = item.time_ns;
    rec_new.count = 32'd1;
    rec_new.total = mode_blocked ? 64'd1 : 64'd0;
  end

  always_comb begin
    elapsed  = item.time_ns - rec_rdata.start;
    cnt_inc  = (rec_rdata.count == '1) ? rec_rdata.count : rec_rdata.count + 32'd1;
    tot_inc  = (rec_rdata.total == '1) ? rec_rdata.total : rec_rdata.total + 64'd1;
    rec_next = rec_rdata;
    upd_verdict = VERDICT_PASS;
    if (elapsed < window_ns) begin
      rec_next.count = cnt_inc;
      if (cnt_inc > pass_limit) begin
        rec_next.total = tot_inc;
        upd_verdict    = VERDICT_DROP;
      end else if (mode_blocked) begin
        rec_next.total = tot_inc;
        upd_verdict    = VERDICT_DROP;
      end
    end else begin
      rec_next.start = item.time_ns;
      rec_next.count = 32'd1;
      if (mode_blocked) begin
        rec_next.total = tot_inc;
        upd_verdict    = VERDICT_DROP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_pass) begin
      pend.verdict       <= VERDICT_PASS;
      pend.blocked_total <= '0;
    end else if (cmd.set_abort) begin
      pend.verdict       <= VERDICT_ABORT;
      pend.blocked_total <= '0;
    end else if (cmd.rate_new) begin
      pend.verdict       <= mode_blocked ? VERDICT_DROP : VERDICT_PASS;
      pend.blocked_total <= rec_new.total;
    end else if (cmd.rate_upd) begin
      pend.verdict       <= upd_verdict;
      pend.blocked_total <= rec_next.total;
    end
  end

  // Output register: a finished word waits here while the next is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item <= pend;
    end
  end

  always_comb begin
    stat.checked = (item.frame_length >= MIN_CHECKED_LEN) &&
                   (item.ether_type == ETH_IPV4) &&
                   (item.ip_protocol == PROTO_UDP) &&
                   ((item.source_port == watched_port) ||
                    (item.dest_port == watched_port));
    stat.is_insert   = (item.opcode == OP_INSERT);
    stat.exc_end     = (idx[EXC_CW-1:0] == exc_fill);
    stat.exc_hit     = (exc_rdata == item.source_address);
    stat.exc_full    = (exc_fill == EXC_CW'(EXC_ENTRIES));
    stat.rate_end    = (idx[RATE_CW-1:0] == rate_fill);
    stat.rate_hit    = (rate_key_rdata == item.source_address);
    stat.rate_full   = (rate_fill == RATE_CW'(RATE_ENTRIES));
    stat.out_blocked = out_valid && !out_ready;
  end

endmodule

FILE: design/ntp_source_rate_limiter_core.sv
// Per-source rate limiter for UDP traffic on one watched port.
// Input channel (in_valid/in_ready/in_item) takes one parsed packet header or
// one exception insert per word; output channel (out_valid/out_ready/out_item)
// returns exactly one verdict word for each input word, in order.
// The user must write configuration through cfg_we/cfg_index/cfg_data
// while idle; the block itself does not enforce this. An unchecked packet
// goes from the exception read state straight to the finish state. A checked
// packet scans the exception table and then, on a miss there, the rate table
// linearly, a read state and a compare state per live entry, through one read
// port per table; an exception insert scans only the exception table. The
// block takes a new word only in its idle state, after the last is emitted.
// Reset empties both tables at once (fill counts to zero) and loads the
// default configuration; no clearing pass is needed.
// When the receiver stalls, a finished word waits in the output register;
// the block still takes and works on the next word and holds its result
// until the output register frees.
module ntp_source_rate_limiter_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nsrl_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nsrl_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import nsrl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  nsrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nsrl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
